/* rtl/pcc_pkg.sv */
package pcc_pkg;

  // Store depth default; the top level takes it as a parameter.
  localparam int unsigned MAX_BOXES_DEF = 64;

  // Field widths.
  localparam int unsigned COORD_W = 21;
  localparam int unsigned SIZE_W  = 20;
  localparam int unsigned ROT_W   = 9;
  localparam int unsigned CLR_W   = 17;
  localparam int unsigned SLOT_W  = 6;

  // Half-micrometre geometry: edges, gaps, squares and the clearance limit.
  localparam int unsigned EDGE_W  = 24;
  localparam int unsigned GAP_W   = 24;
  localparam int unsigned PROD_W  = 2 * GAP_W;
  localparam int unsigned LIM_W   = 2 * (CLR_W + 1);

  // Stream and configuration port widths.
  localparam int unsigned S_DATA_W = 96;
  localparam int unsigned S_USER_W = 3;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned M_USER_W = 2;
  localparam int unsigned CFG_A_W  = 3;
  localparam int unsigned CFG_D_W  = 21;

  // Rotation codes in degrees.
  localparam logic [ROT_W-1:0] ROT_0   = 9'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 9'd90;
  localparam logic [ROT_W-1:0] ROT_180 = 9'd180;
  localparam logic [ROT_W-1:0] ROT_270 = 9'd270;
  localparam logic [ROT_W-1:0] ROT_360 = 9'd360;

  // Register reset values.
  localparam logic [COORD_W-1:0] BOARD_W_RST   = 21'd100000;
  localparam logic [COORD_W-1:0] BOARD_H_RST   = 21'd100000;
  localparam logic [CLR_W-1:0]   CLEARANCE_RST = 17'd200;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_WIDTH     = 3'd2,
    REG_HEIGHT    = 3'd3,
    REG_CLEARANCE = 3'd4
  } cfg_reg_e;

  typedef enum logic [M_USER_W-1:0] {
    KIND_OVERLAP   = 2'd0,
    KIND_CLEARANCE = 2'd1,
    KIND_SUMMARY   = 2'd2
  } kind_e;

endpackage

/* rtl/placement_clearance_checker.sv */
// Placement clearance checker. Each input item is one component placement;
// the block forms its body box (width and height swapped at 90 or 270
// degrees), checks the rotation and the board edges, compares the box with
// every box stored since the last new_design, and sends one item per
// overlapping or too-close earlier box, in ascending slot order, followed by
// a summary item with tlast set. Geometry is held in half-micrometres and
// the clearance test compares squared corner gaps, so every result is exact.
// One placement is handled at a time and s_axis_tready is low meanwhile. A
// placement goes through set-up, where the box edges and the squared
// clearance limit are formed, then for each stored box a gap step, the
// squares of the x gap and the y gap and a compare (an overlap skips the
// squares), each pair item being sent where it is found, then a step that
// stores the box and the summary item; every item is held while
// m_axis_tready stays low. The single 24x24 multiplier squares the
// clearance limit, the x gap and the y gap in turn. A box dropped because
// the store is full, an unknown reference and a placement without geometry
// skip the compares and the store and send only the summary item.
// Configuration writes are taken at any time but belong between placements.
module placement_clearance_checker #(
  parameter int unsigned MAX_BOXES = pcc_pkg::MAX_BOXES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Placements
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // x_center[20:0], y_center[41:21], box_width[61:42], box_height[81:62],
  // rot_angle[90:82], zero[95:91]
  input  logic [pcc_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // new_design[0], ref_found[1], has_box[2]
  input  logic [pcc_pkg::S_USER_W-1:0]  s_axis_tuser,
  // Results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // other_slot[5:0], this_slot[11:6], stored[12], on_board[13],
  // rotation_ok[14], ref_ok[15], store_full[16], zero[23:17]
  output logic [pcc_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [pcc_pkg::M_USER_W-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcc_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [pcc_pkg::CFG_D_W-1:0]   cfg_data_i
);

  localparam int unsigned SlotW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BOXES + 1);
  localparam int unsigned EW    = pcc_pkg::EDGE_W;
  localparam int unsigned GW    = pcc_pkg::GAP_W;
  localparam int unsigned PW    = pcc_pkg::PROD_W;
  localparam int unsigned LW    = pcc_pkg::LIM_W;
  localparam int unsigned CW    = pcc_pkg::COORD_W;
  localparam int unsigned SW    = pcc_pkg::SIZE_W;
  localparam int unsigned RW    = pcc_pkg::ROT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LIMIT,
    ST_GAP,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_STORE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic signed [CW-1:0]           org_x_q, org_y_q;
  logic [CW-1:0]                  brd_w_q, brd_h_q;
  logic [pcc_pkg::CLR_W-1:0]      clr_q;

  // Latched placement
  logic signed [CW-1:0] xc_q, yc_q;
  logic [SW-1:0]        w_q, h_q;
  logic [RW-1:0]        rot_q;
  logic                 ref_q, has_q;

  // Working geometry
  logic signed [EW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [EW-1:0] bx0_q, bx1_q, by0_q, by1_q;
  logic                 geo_q;
  logic [GW-1:0]        gx_q, gy_q;
  logic [PW-1:0]        sqx_q, sqy_q;
  logic [LW-1:0]        lim_q;

  // Box store and its read port
  logic [2*EW-1:0]      box_x_mem [MAX_BOXES];
  logic [2*EW-1:0]      box_y_mem [MAX_BOXES];
  logic [2*EW-1:0]      rd_x_q, rd_y_q;

  logic [CntW-1:0]      count_q;
  logic [SlotW-1:0]     idx_q, idx_d, slot_q;

  // Result registers
  logic                 stored_q, inb_q, rot_ok_q, full_q, last_q;
  pcc_pkg::kind_e       kind_q;
  logic [SlotW-1:0]     other_q;

  // Combinational helpers
  logic [SW-1:0]        w_rot, h_rot;
  logic [RW-1:0]        rot_fold;
  logic                 rot_legal;
  logic signed [EW-1:0] ox0, ox1, oy0, oy1;
  logic signed [EW:0]   dxa, dxb, dya, dyb, gxs, gys;
  logic                 overlap;
  logic [GW-1:0]        mul_a;
  logic [PW-1:0]        prod;
  logic [PW:0]          sq_sum;
  logic                 near;
  logic                 last_box;
  logic                 advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      brd_w_q <= pcc_pkg::BOARD_W_RST;
      brd_h_q <= pcc_pkg::BOARD_H_RST;
      clr_q   <= pcc_pkg::CLEARANCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        pcc_pkg::REG_ORIGIN_X:  org_x_q <= cfg_data_i;
        pcc_pkg::REG_ORIGIN_Y:  org_y_q <= cfg_data_i;
        pcc_pkg::REG_WIDTH:     brd_w_q <= cfg_data_i;
        pcc_pkg::REG_HEIGHT:    brd_h_q <= cfg_data_i;
        pcc_pkg::REG_CLEARANCE: clr_q   <= cfg_data_i[pcc_pkg::CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // Rotation check and fold; swap width and height at quarter turns.
  always_comb begin
    rot_fold  = (rot_q >= pcc_pkg::ROT_360) ? rot_q - pcc_pkg::ROT_360 : rot_q;
    rot_legal = (rot_q == pcc_pkg::ROT_0)   || (rot_q == pcc_pkg::ROT_90) ||
                (rot_q == pcc_pkg::ROT_180) || (rot_q == pcc_pkg::ROT_270);
    if (rot_fold == pcc_pkg::ROT_90 || rot_fold == pcc_pkg::ROT_270) begin
      w_rot = h_q;
      h_rot = w_q;
    end else begin
      w_rot = w_q;
      h_rot = h_q;
    end
  end

  // Pair test against the stored box read out for idx_q.
  always_comb begin
    ox0 = rd_x_q[EW-1:0];
    ox1 = rd_x_q[2*EW-1:EW];
    oy0 = rd_y_q[EW-1:0];
    oy1 = rd_y_q[2*EW-1:EW];
    overlap = (ox0 < x1_q) && (x0_q < ox1) && (oy0 < y1_q) && (y0_q < oy1);
    dxa = $signed({x0_q[EW-1], x0_q}) - $signed({ox1[EW-1], ox1});
    dxb = $signed({ox0[EW-1], ox0}) - $signed({x1_q[EW-1], x1_q});
    dya = $signed({y0_q[EW-1], y0_q}) - $signed({oy1[EW-1], oy1});
    dyb = $signed({oy0[EW-1], oy0}) - $signed({y1_q[EW-1], y1_q});
    gxs = (dxa > dxb) ? dxa : dxb;
    gys = (dya > dyb) ? dya : dyb;
  end

  // Shared squaring unit: clearance limit, then x gap, then y gap.
  always_comb begin
    case (state_q)
      ST_LIMIT: mul_a = GW'({clr_q, 1'b0});
      ST_SQX:   mul_a = gx_q;
      ST_SQY:   mul_a = gy_q;
      default:  mul_a = '0;
    endcase
    prod   = mul_a * mul_a;
    sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
    near   = sq_sum < (PW + 1)'(lim_q);
  end

  always_comb begin
    last_box = (CntW'(idx_q) + CntW'(1)) == count_q;
    advance  = ((state_q == ST_CMP) && !near) ||
               ((state_q == ST_EMIT) && m_axis_tready && !last_q);
    if (state_q == ST_LIMIT) begin
      idx_d = '0;
    end else if (advance && !last_box) begin
      idx_d = idx_q + SlotW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  // Box store: one write when a placement's box is stored, one registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) begin
      box_x_mem[slot_q] <= {x1_q, x0_q};
      box_y_mem[slot_q] <= {y1_q, y0_q};
    end
    rd_x_q <= box_x_mem[idx_d];
    rd_y_q <= box_y_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            xc_q  <= s_axis_tdata[20:0];
            yc_q  <= s_axis_tdata[41:21];
            w_q   <= s_axis_tdata[61:42];
            h_q   <= s_axis_tdata[81:62];
            rot_q <= s_axis_tdata[90:82];
            ref_q <= s_axis_tuser[1];
            has_q <= s_axis_tuser[2];
            if (s_axis_tuser[0]) begin
              count_q <= '0;
            end
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rot_ok_q <= ref_q ? rot_legal : 1'b1;
          geo_q    <= ref_q && has_q && (w_q != '0) && (h_q != '0);
          x0_q  <= $signed({{2{xc_q[CW-1]}}, xc_q, 1'b0}) - $signed(EW'(w_rot));
          x1_q  <= $signed({{2{xc_q[CW-1]}}, xc_q, 1'b0}) + $signed(EW'(w_rot));
          y0_q  <= $signed({{2{yc_q[CW-1]}}, yc_q, 1'b0}) - $signed(EW'(h_rot));
          y1_q  <= $signed({{2{yc_q[CW-1]}}, yc_q, 1'b0}) + $signed(EW'(h_rot));
          bx0_q <= $signed({{2{org_x_q[CW-1]}}, org_x_q, 1'b0});
          bx1_q <= $signed({{2{org_x_q[CW-1]}}, org_x_q, 1'b0}) +
                   $signed({2'b00, brd_w_q, 1'b0});
          by0_q <= $signed({{2{org_y_q[CW-1]}}, org_y_q, 1'b0});
          by1_q <= $signed({{2{org_y_q[CW-1]}}, org_y_q, 1'b0}) +
                   $signed({2'b00, brd_h_q, 1'b0});
          state_q <= ST_LIMIT;
        end
        ST_LIMIT: begin
          lim_q    <= prod[LW-1:0];
          inb_q    <= !geo_q || !((x0_q < bx0_q) || (y0_q < by0_q) ||
                                  (x1_q > bx1_q) || (y1_q > by1_q));
          stored_q <= 1'b0;
          full_q   <= 1'b0;
          slot_q   <= '0;
          if (!geo_q) begin
            kind_q  <= pcc_pkg::KIND_SUMMARY;
            other_q <= '0;
            last_q  <= 1'b1;
            state_q <= ST_EMIT;
          end else if (count_q == CntW'(MAX_BOXES)) begin
            full_q  <= 1'b1;
            kind_q  <= pcc_pkg::KIND_SUMMARY;
            other_q <= '0;
            last_q  <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            slot_q   <= count_q[SlotW-1:0];
            stored_q <= 1'b1;
            state_q  <= (count_q == '0) ? ST_STORE : ST_GAP;
          end
        end
        ST_GAP: begin
          gx_q <= gxs[EW] ? '0 : gxs[GW-1:0];
          gy_q <= gys[EW] ? '0 : gys[GW-1:0];
          if (overlap) begin
            kind_q  <= pcc_pkg::KIND_OVERLAP;
            other_q <= idx_q;
            last_q  <= 1'b0;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_SQX;
          end
        end
        ST_SQX: begin
          sqx_q   <= prod;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          sqy_q   <= prod;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (near) begin
            kind_q  <= pcc_pkg::KIND_CLEARANCE;
            other_q <= idx_q;
            last_q  <= 1'b0;
            state_q <= ST_EMIT;
          end else begin
            state_q <= last_box ? ST_STORE : ST_GAP;
          end
        end
        ST_STORE: begin
          count_q <= count_q + CntW'(1);
          kind_q  <= pcc_pkg::KIND_SUMMARY;
          other_q <= '0;
          last_q  <= 1'b1;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold the item until it is taken, then resume the scan or finish.
          if (m_axis_tready) begin
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= last_box ? ST_STORE : ST_GAP;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {7'b0, full_q, ref_q, rot_ok_q, inb_q, stored_q,
                          pcc_pkg::SLOT_W'(slot_q), pcc_pkg::SLOT_W'(other_q)};

endmodule
